// ----- design/tsi_pkg.sv -----
package tsi_pkg;

  // Coordinate and derived arithmetic widths.
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int CRS_W      = PROD_W + 1;

  // Point/edge side tests: each segment endpoint against each triangle edge.
  localparam int NPT    = 2;
  localparam int NEDGE  = 3;
  localparam int NSIDE  = NPT * NEDGE;
  // Cross products: the side tests, then D, s and t for each edge.
  localparam int NCRS   = NSIDE + 3 * NEDGE;
  localparam int NPROD  = 2 * NCRS;
  localparam int EDGE_BASE = NSIDE;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [CRS_W-1:0]      crs_t;
  typedef logic        [CRS_W-1:0]      mag_t;

  // Triangle vertices and segment endpoints of one word.
  typedef struct packed {
    coord_t [NEDGE-1:0] vx;
    coord_t [NEDGE-1:0] vy;
    coord_t [NPT-1:0]   px;
    coord_t [NPT-1:0]   py;
  } geo_t;

  // Multiplier operands plus the endpoint bounding-box flags.
  typedef struct packed {
    diff_t [NPROD-1:0]  opa;
    diff_t [NPROD-1:0]  opb;
    logic  [NSIDE-1:0]  bnd;
  } opnd_t;

  // Raw products plus bounding-box flags.
  typedef struct packed {
    prod_t [NPROD-1:0]  prod;
    logic  [NSIDE-1:0]  bnd;
  } prod_stage_t;

  // Sign, zero and magnitude of each cross product.
  typedef struct packed {
    logic  [NCRS-1:0]   zero;
    logic  [NCRS-1:0]   neg;
    mag_t  [NCRS-1:0]   mag;
    logic  [NSIDE-1:0]  bnd;
  } flag_t;

endpackage

// ----- design/triangle_segment_intersect.sv -----
// Triangle versus segment hit test in 2D. Each input word carries the
// three vertices of a triangle and the two endpoints of a segment, signed
// Q8.8; out_hit is 1 when an endpoint lies inside or on the triangle or
// the segment crosses a triangle edge (edges parallel to the segment never
// count as crossings). All arithmetic is exact. The datapath is a
// five-stage pipeline: operand differences, 30 parallel 17x17 multipliers,
// cross-product subtraction, sign and magnitude extraction, and the final
// ratio compares. It accepts one word every cycle and returns each result
// after the five registered stages; the whole pipeline holds while a finished
// result waits on out_ready.
module triangle_segment_intersect import tsi_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  coord_t in_vertex_a_x,
  input  coord_t in_vertex_a_y,
  input  coord_t in_vertex_b_x,
  input  coord_t in_vertex_b_y,
  input  coord_t in_vertex_c_x,
  input  coord_t in_vertex_c_y,
  input  coord_t in_seg_start_x,
  input  coord_t in_seg_start_y,
  input  coord_t in_seg_end_x,
  input  coord_t in_seg_end_y,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   out_hit
);

  localparam int NSTAGE = 5;

  logic [NSTAGE-1:0] vld_r;
  logic [NSTAGE-1:0] vld_nxt;
  logic              adv;
  geo_t              geo;
  opnd_t             opnd;
  prod_stage_t       prod;
  flag_t             flag;

  // The pipeline moves whenever the output stage is empty or being taken.
  assign adv      = !vld_r[NSTAGE-1] || out_ready;
  assign in_ready = adv;

  // Gather the input word.
  assign geo.vx = {in_vertex_c_x, in_vertex_b_x, in_vertex_a_x};
  assign geo.vy = {in_vertex_c_y, in_vertex_b_y, in_vertex_a_y};
  assign geo.px = {in_seg_end_x, in_seg_start_x};
  assign geo.py = {in_seg_end_y, in_seg_start_y};

  // Valid bits travel alongside the data stages.
  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  tsi_operand u_operand (
    .clk  (clk),
    .en   (adv),
    .geo  (geo),
    .opnd (opnd)
  );

  tsi_product u_product (
    .clk  (clk),
    .en   (adv),
    .opnd (opnd),
    .prod (prod)
  );

  tsi_cross u_cross (
    .clk  (clk),
    .en   (adv),
    .prod (prod),
    .flag (flag)
  );

  tsi_decide u_decide (
    .clk  (clk),
    .en   (adv),
    .flag (flag),
    .hit  (out_hit)
  );

  assign out_valid = vld_r[NSTAGE-1];

endmodule

// ----- design/tsi_operand.sv -----
module tsi_operand import tsi_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  geo_t  geo,
  output opnd_t opnd
);

  opnd_t opnd_r;
  opnd_t opnd_nxt;

  // Exact difference of two coordinates, one bit wider.
  function automatic diff_t sub_d(input coord_t a, input coord_t b);
    sub_d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

  // True when p lies between a and b inclusive, in either order.
  function automatic logic in_rng(input coord_t p, input coord_t a, input coord_t b);
    in_rng = ((p >= a) && (p <= b)) || ((p >= b) && (p <= a));
  endfunction

  // Build the operand pairs of every cross product. Edge e runs from
  // vertex e to the next vertex, wrapping from C back to A.
  always_comb begin
    diff_t ux, uy, sx, sy, wx, wy;
    opnd_nxt = '0;
    sx = sub_d(geo.px[1], geo.px[0]);
    sy = sub_d(geo.py[1], geo.py[0]);
    for (int e = 0; e < NEDGE; e++) begin
      // Side tests of each endpoint against this edge.
      for (int p = 0; p < NPT; p++) begin
        opnd_nxt.opa[2*(p*NEDGE+e)]   = sub_d(geo.px[p], geo.vx[(e+1)%NEDGE]);
        opnd_nxt.opb[2*(p*NEDGE+e)]   = sub_d(geo.vy[e], geo.vy[(e+1)%NEDGE]);
        opnd_nxt.opa[2*(p*NEDGE+e)+1] = sub_d(geo.vx[e], geo.vx[(e+1)%NEDGE]);
        opnd_nxt.opb[2*(p*NEDGE+e)+1] = sub_d(geo.py[p], geo.vy[(e+1)%NEDGE]);
        opnd_nxt.bnd[p*NEDGE+e] = in_rng(geo.px[p], geo.vx[e], geo.vx[(e+1)%NEDGE]) &&
                                  in_rng(geo.py[p], geo.vy[e], geo.vy[(e+1)%NEDGE]);
      end
      // Parametric crossing terms: D = u x v, s = v x w, t = u x w.
      ux = sub_d(geo.vx[(e+1)%NEDGE], geo.vx[e]);
      uy = sub_d(geo.vy[(e+1)%NEDGE], geo.vy[e]);
      wx = sub_d(geo.vx[e], geo.px[0]);
      wy = sub_d(geo.vy[e], geo.py[0]);
      opnd_nxt.opa[2*(EDGE_BASE+3*e)]     = ux;
      opnd_nxt.opb[2*(EDGE_BASE+3*e)]     = sy;
      opnd_nxt.opa[2*(EDGE_BASE+3*e)+1]   = uy;
      opnd_nxt.opb[2*(EDGE_BASE+3*e)+1]   = sx;
      opnd_nxt.opa[2*(EDGE_BASE+3*e+1)]   = sx;
      opnd_nxt.opb[2*(EDGE_BASE+3*e+1)]   = wy;
      opnd_nxt.opa[2*(EDGE_BASE+3*e+1)+1] = sy;
      opnd_nxt.opb[2*(EDGE_BASE+3*e+1)+1] = wx;
      opnd_nxt.opa[2*(EDGE_BASE+3*e+2)]   = ux;
      opnd_nxt.opb[2*(EDGE_BASE+3*e+2)]   = wy;
      opnd_nxt.opa[2*(EDGE_BASE+3*e+2)+1] = uy;
      opnd_nxt.opb[2*(EDGE_BASE+3*e+2)+1] = wx;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      opnd_r <= opnd_nxt;
    end
  end

  assign opnd = opnd_r;

endmodule

// ----- design/tsi_product.sv -----
module tsi_product import tsi_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  opnd_t       opnd,
  output prod_stage_t prod
);

  prod_stage_t prod_r;

  // One 17x17 signed multiplier per operand pair, registered.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NPROD; i++) begin
        prod_r.prod[i] <= PROD_W'($signed(opnd.opa[i]) * $signed(opnd.opb[i]));
      end
      prod_r.bnd <= opnd.bnd;
    end
  end

  assign prod = prod_r;

endmodule

// ----- design/tsi_cross.sv -----
module tsi_cross import tsi_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  prod_stage_t prod,
  output flag_t       flag
);

  crs_t [NCRS-1:0]  crs_r;
  logic [NSIDE-1:0] bnd_r;
  flag_t            flag_r;

  // First stage: each cross product is the difference of two products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCRS; i++) begin
        crs_r[i] <= $signed({prod.prod[2*i][PROD_W-1], prod.prod[2*i]}) -
                    $signed({prod.prod[2*i+1][PROD_W-1], prod.prod[2*i+1]});
      end
      bnd_r <= prod.bnd;
    end
  end

  // Second stage: zero flag, sign and magnitude of each cross product.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NCRS; i++) begin
        flag_r.zero[i] <= (crs_r[i] == '0);
        flag_r.neg[i]  <= crs_r[i][CRS_W-1];
        flag_r.mag[i]  <= crs_r[i][CRS_W-1] ? mag_t'(-crs_r[i]) : mag_t'(crs_r[i]);
      end
      flag_r.bnd <= bnd_r;
    end
  end

  assign flag = flag_r;

endmodule

// ----- design/tsi_decide.sv -----
module tsi_decide import tsi_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  flag_t flag,
  output logic  hit
);

  logic hit_r;
  logic hit_nxt;

  // True when n/d lies in [0,1]; d is known to be nonzero.
  function automatic logic ratio_unit(input logic nz, input logic nn, input mag_t nm,
                                      input logic dn, input mag_t dm);
    ratio_unit = nz || ((nn == dn) && (nm <= dm));
  endfunction

  // Combine endpoint-inside tests and the crossing test of each edge.
  always_comb begin
    logic any_pos, any_neg, on_edge, crossed;
    hit_nxt = 1'b0;
    for (int p = 0; p < NPT; p++) begin
      any_pos = 1'b0;
      any_neg = 1'b0;
      on_edge = 1'b0;
      for (int e = 0; e < NEDGE; e++) begin
        any_pos = any_pos | (!flag.zero[p*NEDGE+e] && !flag.neg[p*NEDGE+e]);
        any_neg = any_neg | (!flag.zero[p*NEDGE+e] &&  flag.neg[p*NEDGE+e]);
        on_edge = on_edge | (flag.zero[p*NEDGE+e] && flag.bnd[p*NEDGE+e]);
      end
      hit_nxt = hit_nxt | on_edge | !(any_pos && any_neg);
    end
    for (int e = 0; e < NEDGE; e++) begin
      crossed = !flag.zero[EDGE_BASE+3*e] &&
                ratio_unit(flag.zero[EDGE_BASE+3*e+1], flag.neg[EDGE_BASE+3*e+1],
                           flag.mag[EDGE_BASE+3*e+1], flag.neg[EDGE_BASE+3*e],
                           flag.mag[EDGE_BASE+3*e]) &&
                ratio_unit(flag.zero[EDGE_BASE+3*e+2], flag.neg[EDGE_BASE+3*e+2],
                           flag.mag[EDGE_BASE+3*e+2], flag.neg[EDGE_BASE+3*e],
                           flag.mag[EDGE_BASE+3*e]);
      hit_nxt = hit_nxt | crossed;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule
